// ===== design/assert_macros.svh =====
// Assertion helpers used by the parser engine RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SCFP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// When trig holds, cond must hold in the next cycle.
`define SCFP_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ===== design/scfp_pkg.sv =====
`default_nettype none

package scfp_pkg;

	localparam int TOKEN_SLOTS_DEF = 4;
	localparam int DATA_MAX_DEF    = 20;

	localparam int KIND_W   = 3;
	localparam int SLOT_W   = 5;
	localparam int VALUE_W  = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 8;

	localparam logic [7:0] CH_HASH  = "#";
	localparam logic [7:0] CH_SEMI  = ";";
	localparam logic [7:0] CH_DOT   = ".";
	localparam logic [7:0] CH_DASH  = "-";
	localparam logic [7:0] CH_COLON = ":";

	localparam logic [KIND_W-1:0] KIND_CMD  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_OPT  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SUB  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DATA = 3'd3;
	localparam logic [KIND_W-1:0] KIND_END  = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_SYNTAX  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BADCHAR = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_ABANDON = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [SLOT_W-1:0]   slot;
		logic [VALUE_W-1:0]  value;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  data_count;
	} result_t;

	// Bit 4 flags a hex digit, bits 3:0 carry its value.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'b0;
		if (c >= "0" && c <= "9") begin
			r = {1'b1, 4'(c - "0")};
		end else if (c >= "A" && c <= "F") begin
			r = {1'b1, 4'(c - "A" + 8'd10)};
		end else if (c >= "a" && c <= "f") begin
			r = {1'b1, 4'(c - "a" + 8'd10)};
		end
		return r;
	endfunction

	function automatic logic name_ok(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z");
	endfunction

endpackage

`default_nettype wire

// ===== design/scfp_text_if.sv =====
`default_nettype none

interface scfp_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== design/scfp_token_if.sv =====
`default_nettype none

interface scfp_token_if;
	logic                          valid;
	logic                          ready;
	logic [scfp_pkg::KIND_W-1:0]   kind;
	logic [scfp_pkg::SLOT_W-1:0]   slot;
	logic [scfp_pkg::VALUE_W-1:0]  value;
	logic [scfp_pkg::STATUS_W-1:0] status;
	logic [scfp_pkg::COUNT_W-1:0]  data_count;

	modport source (output valid, output kind, output slot, output value,
		output status, output data_count, input ready);
	modport sink (input valid, input kind, input slot, input value,
		input status, input data_count, output ready);
endinterface

`default_nettype wire

// ===== design/serial_command_frame_parser_core.sv =====
// Channel  Dir  Payload                                 Accept
// text     in   rx_byte[7:0]                            valid && ready
// token    out  kind[2:0] slot[4:0] value[7:0]          valid && ready
//               status[1:0] data_count[7:0]
//
// One byte per cycle sustained while token takes results; a taken byte passes through
// the input register, then the parse engine's result register, before its result is offered.
// Reset is asynchronous: the parser returns to outside-frame and both stages empty.
// A result waiting on token holds the input stage; text.ready drops only when the input
// stage is full and cannot move on in the same cycle.
`default_nettype none

module serial_command_frame_parser_core #(
	parameter int TOKEN_SLOTS = scfp_pkg::TOKEN_SLOTS_DEF,
	parameter int DATA_MAX    = scfp_pkg::DATA_MAX_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	scfp_text_if.sink   text,
	scfp_token_if.source token
);
	import scfp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       step;
	logic       res_valid;
	result_t    res;

	// advance the input stage when the result register is free or being drained
	assign step       = valid_s1 && (!res_valid || token.ready);
	assign text.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.rx_byte;
		end
	end

	scfp_engine #(
		.TOKEN_SLOTS (TOKEN_SLOTS),
		.DATA_MAX    (DATA_MAX)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.take      (token.ready),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	assign token.valid      = res_valid;
	assign token.kind       = res.kind;
	assign token.slot       = res.slot;
	assign token.value      = res.value;
	assign token.status     = res.status;
	assign token.data_count = res.data_count;

endmodule

`default_nettype wire

// ===== design/scfp_engine.sv =====
`default_nettype none
`include "assert_macros.svh"

module scfp_engine #(
	parameter int TOKEN_SLOTS = scfp_pkg::TOKEN_SLOTS_DEF,
	parameter int DATA_MAX    = scfp_pkg::DATA_MAX_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic              take,
	input  wire logic [7:0]        rx_byte,
	output logic                   res_valid,
	output scfp_pkg::result_t      res
);
	import scfp_pkg::*;

	localparam int               TS_W     = $clog2(TOKEN_SLOTS + 1);
	localparam logic [TS_W-1:0]  SLOT_LIM = TS_W'(TOKEN_SLOTS);
	localparam logic [7:0]       DATA_LIM = 8'(DATA_MAX);

	typedef enum logic [2:0] {
		MODE_OUT,
		MODE_CMD,
		MODE_OPT,
		MODE_SUB,
		MODE_DAT
	} mode_t;

	mode_t            mode_q, mode_d;
	logic [TS_W-1:0]  slot_q, slot_d;
	logic [7:0]       idx_q, idx_d;
	logic [3:0]       hi_q, hi_d;
	logic             pend_q, pend_d;
	logic             syn_q, syn_d;
	logic             bad_q, bad_d;
	logic             res_valid_q;
	result_t          res_q, res_d;
	logic             emit;

	logic [4:0]       hex_w;
	logic             slot_kept;
	logic [TS_W-1:0]  slot_inc;
	logic             name_hit;
	logic [KIND_W-1:0] name_kind;

	assign hex_w     = hex_decode(rx_byte);
	assign slot_kept = slot_q < SLOT_LIM;
	assign slot_inc  = slot_kept ? slot_q + TS_W'(1) : slot_q;

	always_comb begin
		mode_d    = mode_q;
		slot_d    = slot_q;
		idx_d     = idx_q;
		hi_d      = hi_q;
		pend_d    = pend_q;
		syn_d     = syn_q;
		bad_d     = bad_q;
		emit      = 1'b0;
		res_d     = '0;
		name_hit  = 1'b0;
		name_kind = KIND_CMD;

		if (rx_byte == CH_HASH) begin
			// abandon any open frame, then open a fresh one
			if (mode_q != MODE_OUT) begin
				emit             = 1'b1;
				res_d.kind       = KIND_END;
				res_d.status     = STATUS_ABANDON;
				res_d.data_count = idx_q;
			end
			mode_d = MODE_CMD;
			slot_d = '0;
			idx_d  = '0;
			hi_d   = '0;
			pend_d = 1'b0;
			syn_d  = 1'b0;
			bad_d  = 1'b0;
		end else if (mode_q == MODE_OUT) begin
			// drop bytes outside a frame
		end else if (rx_byte == CH_SEMI) begin
			emit             = 1'b1;
			res_d.kind       = KIND_END;
			res_d.data_count = idx_q;
			if (syn_q || pend_q) begin
				res_d.status = STATUS_SYNTAX;
			end else if (bad_q) begin
				res_d.status = STATUS_BADCHAR;
			end else begin
				res_d.status = STATUS_OK;
			end
			mode_d = MODE_OUT;
		end else begin
			unique case (mode_q) inside
				MODE_CMD: begin
					if (rx_byte == CH_DOT) begin
						slot_d = slot_inc;
					end else if (rx_byte == CH_DASH) begin
						mode_d = MODE_OPT;
						slot_d = '0;
					end else if (rx_byte == CH_COLON) begin
						mode_d = MODE_DAT;
					end else begin
						name_hit  = 1'b1;
						name_kind = KIND_CMD;
					end
				end
				MODE_OPT, MODE_SUB: begin
					if (rx_byte == CH_DASH) begin
						mode_d = MODE_OPT;
						slot_d = slot_inc;
					end else if (rx_byte == CH_COLON) begin
						mode_d = MODE_DAT;
					end else if (rx_byte == CH_DOT) begin
						// second dot in a kept suboption is a bad character
						if (mode_q == MODE_OPT) begin
							mode_d = MODE_SUB;
						end else if (slot_kept) begin
							bad_d = 1'b1;
						end
					end else begin
						name_hit  = 1'b1;
						name_kind = (mode_q == MODE_OPT) ? KIND_OPT : KIND_SUB;
					end
				end
				MODE_DAT: begin
					if (!hex_w[4]) begin
						syn_d = 1'b1;
					end else if (!pend_q) begin
						hi_d   = hex_w[3:0];
						pend_d = 1'b1;
					end else begin
						pend_d = 1'b0;
						if (idx_q != 8'hFF) begin
							idx_d = idx_q + 8'd1;
						end
						if (idx_q < DATA_LIM) begin
							emit        = 1'b1;
							res_d.kind  = KIND_DATA;
							res_d.slot  = idx_q[SLOT_W-1:0];
							res_d.value = {hi_q, hex_w[3:0]};
						end
					end
				end
				default: begin
					mode_d = MODE_OUT;
				end
			endcase
		end

		if (name_hit && slot_kept) begin
			if (!name_ok(rx_byte)) begin
				bad_d = 1'b1;
			end
			emit        = 1'b1;
			res_d.kind  = name_kind;
			res_d.slot  = SLOT_W'(slot_q);
			res_d.value = rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_OUT;
			slot_q      <= '0;
			idx_q       <= '0;
			hi_q        <= '0;
			pend_q      <= 1'b0;
			syn_q       <= 1'b0;
			bad_q       <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (step) begin
				mode_q      <= mode_d;
				slot_q      <= slot_d;
				idx_q       <= idx_d;
				hi_q        <= hi_d;
				pend_q      <= pend_d;
				syn_q       <= syn_d;
				bad_q       <= bad_d;
				res_valid_q <= emit;
				res_q       <= res_d;
			end else if (take) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`SCFP_ASSERT(a_step_room, step |-> (!res_valid_q || take), "step overwrote a pending item")
	`SCFP_ASSERT(a_slot_sat, slot_q <= SLOT_LIM, "token slot ran past its limit")
	`SCFP_ASSERT_NEXT(a_hash_opens, step && rx_byte == CH_HASH, mode_q == MODE_CMD && idx_q == '0 && !pend_q, "hash did not open a clean frame")
	`SCFP_ASSERT(a_data_slot, (res_valid_q && res_q.kind == KIND_DATA) |-> ({3'b000, res_q.slot} < DATA_LIM), "data item beyond data limit")

endmodule

`default_nettype wire

// ===== sim/serial_command_frame_parser_core_test.sv =====
`timescale 1ns / 100ps

module serial_command_frame_parser_core_test;
	import scfp_pkg::*;

	localparam int TOKEN_SLOTS = TOKEN_SLOTS_DEF;
	localparam int DATA_MAX = DATA_MAX_DEF;
	localparam int RANDOM_ITEMS = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_AT = 1500;
	localparam int HOLD_CYCLES = 300;
	localparam int GIANT_FRAME = 3;
	localparam int GIANT_PAIRS = 260;

	typedef enum logic [2:0] {
		OUTSIDE_FRAME, IN_COMMAND, IN_OPTION, IN_SUBOPTION, IN_DATA
	} frame_part_t;

	typedef enum logic [1:0] {
		SINK_STEADY, SINK_MOSTLY, SINK_ALTERNATE, SINK_SPARSE
	} sink_pattern_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       typed;
		logic       produces;
		result_t    want;
	} script_row_t;

	localparam result_t NO_TOKEN = '0;
	localparam int DIRECTED_LEN = 27;
	localparam script_row_t DIRECTED_SCRIPT [DIRECTED_LEN] = '{
		'{8'h00, 1'b1, 1'b0, NO_TOKEN},
		'{8'hFF, 1'b1, 1'b0, NO_TOKEN},
		'{CH_HASH, 1'b1, 1'b0, NO_TOKEN},
		'{"A", 1'b1, 1'b1, {KIND_CMD, 5'd0, 8'h41, STATUS_OK, 8'd0}},
		'{8'hFF, 1'b0, 1'b0, NO_TOKEN},
		'{CH_DOT, 1'b0, 1'b0, NO_TOKEN},
		'{"B", 1'b0, 1'b0, NO_TOKEN},
		'{CH_DASH, 1'b0, 1'b0, NO_TOKEN},
		'{"z", 1'b0, 1'b0, NO_TOKEN},
		'{CH_DOT, 1'b0, 1'b0, NO_TOKEN},
		'{"9", 1'b0, 1'b0, NO_TOKEN},
		'{CH_DOT, 1'b0, 1'b0, NO_TOKEN},
		'{CH_COLON, 1'b0, 1'b0, NO_TOKEN},
		'{"f", 1'b0, 1'b0, NO_TOKEN},
		'{"F", 1'b1, 1'b1, {KIND_DATA, 5'd0, 8'hFF, STATUS_OK, 8'd0}},
		'{"0", 1'b0, 1'b0, NO_TOKEN},
		'{"0", 1'b0, 1'b0, NO_TOKEN},
		'{CH_DASH, 1'b0, 1'b0, NO_TOKEN},
		'{"1", 1'b0, 1'b0, NO_TOKEN},
		'{CH_SEMI, 1'b1, 1'b1, {KIND_END, 5'd0, 8'h00, STATUS_SYNTAX, 8'd2}},
		'{CH_HASH, 1'b1, 1'b0, NO_TOKEN},
		'{"Q", 1'b0, 1'b0, NO_TOKEN},
		'{CH_HASH, 1'b1, 1'b1, {KIND_END, 5'd0, 8'h00, STATUS_ABANDON, 8'd0}},
		'{CH_COLON, 1'b0, 1'b0, NO_TOKEN},
		'{"a", 1'b0, 1'b0, NO_TOKEN},
		'{"b", 1'b0, 1'b0, NO_TOKEN},
		'{CH_SEMI, 1'b1, 1'b1, {KIND_END, 5'd0, 8'h00, STATUS_OK, 8'd1}}
	};

	logic clk;
	logic arst_n;

	scfp_text_if text_ch ();
	scfp_token_if token_ch ();

	serial_command_frame_parser_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_ch),
		.token(token_ch)
	);

	logic [7:0] text_stream [$];
	result_t expected_tokens [$];
	int bytes_taken = 0;
	int tokens_checked = 0;
	int data_tokens = 0;
	int failures = 0;
	int status_tally [4] = '{0, 0, 0, 0};
	int quiet_cycles = 0;

	// parser state as the block should hold it
	frame_part_t frame_part = OUTSIDE_FRAME;
	logic [3:0] slot_ctr = '0;
	logic [7:0] data_pairs = '0;
	logic [3:0] hi_nib = '0;
	logic half_pair = 1'b0;
	logic syn_err = 1'b0;
	logic bad_name = 1'b0;

	task automatic parse_char(input logic [7:0] ch, output logic made, output result_t tok);
		logic is_hex;
		logic [3:0] nib;
		logic [7:0] idx;
		made = 1'b0;
		tok = '0;
		is_hex = 1'b1;
		nib = '0;
		if (ch >= "0" && ch <= "9") begin
			nib = 4'(ch - "0");
		end else if (ch >= "A" && ch <= "F") begin
			nib = 4'(ch - "A" + 8'd10);
		end else if (ch >= "a" && ch <= "f") begin
			nib = 4'(ch - "a" + 8'd10);
		end else begin
			is_hex = 1'b0;
		end
		if (ch == CH_HASH) begin
			if (frame_part != OUTSIDE_FRAME) begin
				made = 1'b1;
				tok.kind = KIND_END;
				tok.status = STATUS_ABANDON;
				tok.data_count = data_pairs;
			end
			frame_part = IN_COMMAND;
			slot_ctr = '0;
			data_pairs = '0;
			hi_nib = '0;
			half_pair = 1'b0;
			syn_err = 1'b0;
			bad_name = 1'b0;
			return;
		end
		if (frame_part == OUTSIDE_FRAME) return;
		if (ch == CH_SEMI) begin
			made = 1'b1;
			tok.kind = KIND_END;
			tok.status = (syn_err || half_pair) ? STATUS_SYNTAX :
				bad_name ? STATUS_BADCHAR : STATUS_OK;
			tok.data_count = data_pairs;
			frame_part = OUTSIDE_FRAME;
			return;
		end
		case (frame_part)
			IN_COMMAND: begin
				if (ch == CH_DOT) begin
					if (slot_ctr < TOKEN_SLOTS) slot_ctr++;
					return;
				end
				if (ch == CH_DASH) begin
					frame_part = IN_OPTION;
					slot_ctr = '0;
					return;
				end
				if (ch == CH_COLON) begin
					frame_part = IN_DATA;
					return;
				end
				tok.kind = KIND_CMD;
			end
			IN_OPTION, IN_SUBOPTION: begin
				if (ch == CH_DASH) begin
					frame_part = IN_OPTION;
					if (slot_ctr < TOKEN_SLOTS) slot_ctr++;
					return;
				end
				if (ch == CH_COLON) begin
					frame_part = IN_DATA;
					return;
				end
				if (ch == CH_DOT) begin
					// a second dot only counts inside a kept slot
					if (frame_part == IN_OPTION) frame_part = IN_SUBOPTION;
					else if (slot_ctr < TOKEN_SLOTS) bad_name = 1'b1;
					return;
				end
				tok.kind = (frame_part == IN_OPTION) ? KIND_OPT : KIND_SUB;
			end
			default: begin
				if (!is_hex) begin
					syn_err = 1'b1;
					return;
				end
				if (!half_pair) begin
					hi_nib = nib;
					half_pair = 1'b1;
					return;
				end
				half_pair = 1'b0;
				idx = data_pairs;
				if (data_pairs != 8'hFF) data_pairs++;
				if (idx < DATA_MAX) begin
					made = 1'b1;
					tok.kind = KIND_DATA;
					tok.slot = 5'(idx);
					tok.value = {hi_nib, nib};
				end
				return;
			end
		endcase
		// name character of a command, option or suboption
		if (slot_ctr >= TOKEN_SLOTS) return;
		if (!((ch >= "0" && ch <= "9") || (ch >= "A" && ch <= "Z"))) bad_name = 1'b1;
		made = 1'b1;
		tok.slot = 5'(slot_ctr);
		tok.value = ch;
	endtask

	function automatic logic [7:0] pick_name_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 88) begin
			r = $urandom_range(0, 35);
			return (r < 10) ? 8'("0" + r) : 8'("A" + r - 10);
		end
		if (r < 95) return 8'("a" + $urandom_range(0, 25));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_hex_char();
		int r;
		r = $urandom_range(0, 21);
		if (r < 10) return 8'("0" + r);
		if (r < 16) return 8'("A" + r - 10);
		return 8'("a" + r - 16);
	endfunction

	function automatic logic [7:0] pick_junk_char();
		case ($urandom_range(0, 4))
			0: return CH_DASH;
			1: return CH_DOT;
			2: return CH_COLON;
			3: return "g";
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic push_name();
		int len;
		len = $urandom_range(1, 3);
		repeat (len) text_stream.push_back(pick_name_char());
	endtask

	// mostly well-formed frames with random content, some broken on purpose
	task automatic compose_frame(input bit giant);
		int n_cmd;
		int n_opt;
		int n_pairs;
		text_stream.push_back(CH_HASH);
		n_cmd = $urandom_range(1, 6);
		for (int i = 0; i < n_cmd; i++) begin
			if (i > 0) text_stream.push_back(CH_DOT);
			push_name();
		end
		n_opt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		repeat (n_opt) begin
			text_stream.push_back(CH_DASH);
			push_name();
			if ($urandom_range(0, 1) == 1) begin
				text_stream.push_back(CH_DOT);
				push_name();
				if ($urandom_range(0, 15) == 0) begin
					text_stream.push_back(CH_DOT);
					push_name();
				end
			end
		end
		if ($urandom_range(0, 19) != 0) begin
			text_stream.push_back(CH_COLON);
			if (giant) n_pairs = GIANT_PAIRS;
			else if ($urandom_range(0, 6) == 0) n_pairs = $urandom_range(18, 26);
			else n_pairs = $urandom_range(0, 8);
			repeat (n_pairs) begin
				text_stream.push_back(pick_hex_char());
				text_stream.push_back(pick_hex_char());
				if ($urandom_range(0, 39) == 0) text_stream.push_back(pick_junk_char());
			end
			if ($urandom_range(0, 19) == 0) text_stream.push_back(pick_hex_char());
		end
		// leave some frames open so the next hash abandons them
		if ($urandom_range(0, 19) != 0) text_stream.push_back(CH_SEMI);
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 4)) text_stream.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin : scoreboard
		logic made;
		result_t want;
		result_t got;
		if (arst_n) begin
			if (text_ch.valid && text_ch.ready) begin
				parse_char(text_ch.rx_byte, made, want);
				if (bytes_taken < DIRECTED_LEN && DIRECTED_SCRIPT[bytes_taken].typed) begin
					made = DIRECTED_SCRIPT[bytes_taken].produces;
					want = DIRECTED_SCRIPT[bytes_taken].want;
				end
				if (made) expected_tokens.push_back(want);
				bytes_taken++;
			end
			if (token_ch.valid && token_ch.ready) begin
				got = {token_ch.kind, token_ch.slot, token_ch.value, token_ch.status,
					token_ch.data_count};
				if (expected_tokens.size() == 0) begin
					$display("%0t unexpected item: kind %0d slot %0d value %02h status %0d count %0d",
						$time, got.kind, got.slot, got.value, got.status, got.data_count);
					failures++;
				end else begin
					want = expected_tokens.pop_front();
					if (got !== want) begin
						$display("%0t mismatch: expected kind %0d slot %0d value %02h status %0d count %0d",
							$time, want.kind, want.slot, want.value, want.status, want.data_count);
						$display("%0t          actual   kind %0d slot %0d value %02h status %0d count %0d",
							$time, got.kind, got.slot, got.value, got.status, got.data_count);
						failures++;
					end
					tokens_checked++;
					if (got.kind == KIND_END) status_tally[got.status]++;
					if (got.kind == KIND_DATA) data_tokens++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_ch.valid && text_ch.ready) || (token_ch.valid && token_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("%0t timeout: no item moved for %0d cycles", $time, QUIET_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : receiver
		int cyc;
		int hold;
		sink_pattern_t pattern;
		token_ch.ready <= 1'b0;
		cyc = 0;
		hold = 0;
		pattern = SINK_STEADY;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (cyc % 50 == 0) pattern = sink_pattern_t'($urandom_range(0, 3));
			// long hold-off so the block backs up into its input
			if (cyc == HOLD_AT) hold = HOLD_CYCLES;
			if (hold > 0) begin
				token_ch.ready <= 1'b0;
				hold--;
			end else begin
				case (pattern)
					SINK_STEADY: token_ch.ready <= 1'b1;
					SINK_MOSTLY: token_ch.ready <= ($urandom_range(0, 3) != 0);
					SINK_ALTERNATE: token_ch.ready <= cyc[0];
					default: token_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
			@(posedge clk);
			cyc++;
		end
	end

	initial begin : sender
		int pos;
		int burst;
		int gap;
		int frame_no;
		text_ch.valid <= 1'b0;
		text_ch.rx_byte <= 8'h00;
		for (int i = 0; i < DIRECTED_LEN; i++) text_stream.push_back(DIRECTED_SCRIPT[i].ch);
		frame_no = 0;
		while (text_stream.size() < DIRECTED_LEN + RANDOM_ITEMS) begin
			compose_frame(frame_no == GIANT_FRAME);
			frame_no++;
		end
		text_stream.push_back(CH_SEMI);
		do @(posedge clk); while (!arst_n);
		pos = 0;
		while (pos < text_stream.size()) begin
			burst = $urandom_range(1, 32);
			while (burst > 0 && pos < text_stream.size()) begin
				text_ch.valid <= 1'b1;
				text_ch.rx_byte <= text_stream[pos];
				do @(posedge clk); while (!text_ch.ready);
				pos++;
				burst--;
			end
			gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				text_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		text_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d bytes in %0d random frames, %0d items checked, %0d of them data bytes",
			bytes_taken, frame_no, tokens_checked, data_tokens);
		$display("frame ends: ok %0d, syntax %0d, bad char %0d, abandoned %0d",
			status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
		if (failures == 0 && expected_tokens.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
